[hdl/rwc_pkg.sv]
// Package for the RGB 5x5 window convolution core: widths, codes, types.
// No dependencies; imported by every module of the core.
package rwc_pkg;

    localparam int KSIZE = 5;
    localparam int HALF = KSIZE / 2;
    localparam int CH_W = 8;
    localparam int PIX_W = 3 * CH_W;

    localparam int CFG_W = 12;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int DIM_W = 14;

    localparam int HEAVY_ROW = 1;
    localparam int HEAVY_COL = 4;
    localparam int HEAVY_GAIN_SHIFT = 2;

    localparam int CSUM_W = 11;
    localparam int TSUM_W = 13;
    localparam int KERNEL_DIV = 25;
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP = (1 << RECIP_SHIFT) / KERNEL_DIV + 1;
    localparam int RECIP_W = 14;
    localparam int PROD_W = TSUM_W + RECIP_W;
    localparam int QUOT_W = PROD_W - RECIP_SHIFT;
    localparam logic [CH_W-1:0] SAT_MAX = 8'hFF;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [KSIZE-1:0][PIX_W-1:0] column_t;
    typedef logic [KSIZE-2:0][PIX_W-1:0] lines_t;

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } csum_t;

    typedef struct packed {
        logic [TSUM_W-1:0] red;
        logic [TSUM_W-1:0] green;
        logic [TSUM_W-1:0] blue;
    } tsum_t;

endpackage

[hdl/rwc_cell.sv]
// One window column cell: five pixels of a column, its position tags,
// and the masked weighted column sum. Depends on rwc_pkg.
module rwc_cell #(
    parameter int CW = 11,
    parameter int RW = 12,
    parameter bit HEAVY = 1'b0
) (
    input  logic                          clk,
    input  logic                          shift,
    input  rwc_pkg::column_t              col_in,
    input  logic [CW-1:0]                 xtag_in,
    input  logic [RW-1:0]                 ytag_in,
    input  logic [rwc_pkg::KSIZE-1:0]     mask,
    output rwc_pkg::column_t              col_out,
    output logic [CW-1:0]                 xtag_out,
    output logic [RW-1:0]                 ytag_out,
    output rwc_pkg::csum_t                csum
);
    import rwc_pkg::*;

    column_t       col_reg;
    logic [CW-1:0] xtag_reg;
    logic [RW-1:0] ytag_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg  <= col_in;
            xtag_reg <= xtag_in;
            ytag_reg <= ytag_in;
        end
    end

    always_comb
    begin
        csum = '0;
        for (int k = 0; k < KSIZE; k++)
        begin
            if (mask[k])
            begin
                if (HEAVY && k == HEAVY_ROW)
                begin
                    csum.red   = csum.red
                        + (CSUM_W'(col_reg[k][CH_W-1:0]) << HEAVY_GAIN_SHIFT);
                    csum.green = csum.green
                        + (CSUM_W'(col_reg[k][2*CH_W-1:CH_W]) << HEAVY_GAIN_SHIFT);
                    csum.blue  = csum.blue
                        + (CSUM_W'(col_reg[k][3*CH_W-1:2*CH_W]) << HEAVY_GAIN_SHIFT);
                end
                else
                begin
                    csum.red   = csum.red + CSUM_W'(col_reg[k][CH_W-1:0]);
                    csum.green = csum.green + CSUM_W'(col_reg[k][2*CH_W-1:CH_W]);
                    csum.blue  = csum.blue + CSUM_W'(col_reg[k][3*CH_W-1:2*CH_W]);
                end
            end
        end
    end

    assign col_out  = col_reg;
    assign xtag_out = xtag_reg;
    assign ytag_out = ytag_reg;

endmodule

[hdl/rwc_line_buf.sv]
// Four-row line buffer: one wide word per column, registered read with
// write-to-read forwarding. Depends on rwc_pkg.
module rwc_line_buf #(
    parameter int DEPTH = 2048,
    parameter int AW = 11
) (
    input  logic            clk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  rwc_pkg::lines_t wr_data,
    output rwc_pkg::lines_t rd_data
);
    import rwc_pkg::*;

    lines_t mem [DEPTH];
    lines_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && wr_addr == rd_addr)
            begin
                rd_reg <= wr_data;
            end
            else
            begin
                rd_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_reg;

endmodule

[hdl/rwc_sum.sv]
// Window total and scaling: adds the five column sums, divides by the
// kernel divisor through a reciprocal, saturates. Depends on rwc_pkg.
module rwc_sum (
    input  logic                      clk,
    input  logic                      en,
    input  rwc_pkg::csum_t            col_sum [rwc_pkg::KSIZE],
    output logic [rwc_pkg::CH_W-1:0]  red,
    output logic [rwc_pkg::CH_W-1:0]  green,
    output logic [rwc_pkg::CH_W-1:0]  blue
);
    import rwc_pkg::*;

    csum_t col_sum_reg [KSIZE];
    tsum_t total_reg;
    tsum_t total_next;

    function automatic logic [CH_W-1:0] scale(input logic [TSUM_W-1:0] s);
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        prod = PROD_W'(s) * PROD_W'(RECIP);
        quot = prod[PROD_W-1:RECIP_SHIFT];
        if (quot > QUOT_W'(SAT_MAX))
        begin
            return SAT_MAX;
        end
        return quot[CH_W-1:0];
    endfunction

    always_comb
    begin
        total_next = '0;
        for (int k = 0; k < KSIZE; k++)
        begin
            total_next.red   = total_next.red + TSUM_W'(col_sum_reg[k].red);
            total_next.green = total_next.green + TSUM_W'(col_sum_reg[k].green);
            total_next.blue  = total_next.blue + TSUM_W'(col_sum_reg[k].blue);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_sum_reg <= col_sum;
            total_reg   <= total_next;
        end
    end

    assign red   = scale(total_reg.red);
    assign green = scale(total_reg.green);
    assign blue  = scale(total_reg.blue);

endmodule

[hdl/rgb_window_convolution_5x5_core.sv]
// RGB 5x5 window convolution core takes one pixel request per clock in raster
// order and returns one filtered pixel per clock once the stream is 2*width+2
// positions past it; each result passes the s1 stage register, the column
// cells, the sum and total registers and the result register. The line buffer
// port and the five-cell column chain set the rate: one column enters the
// chain per accepted request, and the whole pipeline holds only while the
// result register is full and not taken. After the frame, flush requests
// drain the last 2*width+2 results. Depends on rwc_pkg, rwc_cell, rwc_line_buf and rwc_sum.
module rgb_window_convolution_5x5_core #(
    parameter int MAX_WIDTH = rwc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rwc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  logic                           command,
    input  logic [rwc_pkg::CH_W-1:0]       red_in,
    input  logic [rwc_pkg::CH_W-1:0]       green_in,
    input  logic [rwc_pkg::CH_W-1:0]       blue_in,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [rwc_pkg::CH_W-1:0]       red_out,
    output logic [rwc_pkg::CH_W-1:0]       green_out,
    output logic [rwc_pkg::CH_W-1:0]       blue_out,
    output logic                           frame_end
);
    import rwc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 4);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [DIM_W-1:0] w_raw;
    logic [DIM_W-1:0] h_raw;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic [DIM_W-1:0] col_x;
    logic [DIM_W-1:0] row_x;

    logic   en;
    logic   accept;
    logic   in_frame;
    logic   last_pos;
    logic   has_out;
    pixel_t pix;

    logic          s1_valid_reg;
    pixel_t        s1_pix_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_out_reg;
    logic          s1_end_reg;

    logic s2_valid_reg, s2_end_reg;
    logic s3_valid_reg, s3_end_reg;
    logic s4_valid_reg, s4_end_reg;

    logic            result_valid_reg;
    logic [CH_W-1:0] red_out_reg;
    logic [CH_W-1:0] green_out_reg;
    logic [CH_W-1:0] blue_out_reg;
    logic            frame_end_reg;

    lines_t  lb_rd;
    lines_t  lb_wr;
    column_t new_col;
    logic    shift;

    column_t       cell_col  [KSIZE];
    logic [CW-1:0] cell_x    [KSIZE];
    logic [RW-1:0] cell_y    [KSIZE];
    csum_t         cell_sum  [KSIZE];
    logic [KSIZE-1:0] col_ok;
    logic [KSIZE-1:0] row_ok;
    logic [DIM_W-1:0] cx;
    logic [DIM_W-1:0] ry;

    logic [CH_W-1:0] red_q, green_q, blue_q;

    assign w_raw = DIM_W'(width_reg);
    assign h_raw = DIM_W'(height_reg);
    assign w_eff = (w_raw == '0) ? DIM_W'(1)
                 : (w_raw > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_raw;
    assign h_eff = (h_raw == '0) ? DIM_W'(1)
                 : (h_raw > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_raw;

    assign en          = !result_valid_reg || result_ready;
    assign pixel_ready = en;
    assign accept      = pixel_valid && en;

    assign col_x    = DIM_W'(col_reg);
    assign row_x    = DIM_W'(row_reg);
    assign in_frame = row_x < h_eff;
    assign last_pos = (w_eff == DIM_W'(1))
                    ? (row_x == h_eff + DIM_W'(3))
                    : (row_x == h_eff + DIM_W'(2) && col_x == DIM_W'(1));
    assign has_out  = (row_x >= DIM_W'(4))
                   || (row_x == DIM_W'(3) && w_eff != DIM_W'(1))
                   || (row_x == DIM_W'(2) && col_x >= DIM_W'(2));
    assign pix = (command == CMD_PIXEL && in_frame) ? {blue_in, green_in, red_in} : '0;

    always_comb
    begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (last_pos)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_x + DIM_W'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = row_reg + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg     <= accept;
            s2_valid_reg     <= s1_valid_reg && s1_out_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            result_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (accept)
            begin
                s1_pix_reg <= pix;
                s1_col_reg <= col_reg;
                s1_row_reg <= row_reg;
                s1_out_reg <= has_out;
                s1_end_reg <= last_pos;
            end
            s2_end_reg    <= s1_end_reg;
            s3_end_reg    <= s2_end_reg;
            s4_end_reg    <= s3_end_reg;
            frame_end_reg <= s4_end_reg;
            red_out_reg   <= red_q;
            green_out_reg <= green_q;
            blue_out_reg  <= blue_q;
        end
    end

    assign shift = en && s1_valid_reg;

    always_comb
    begin
        lb_wr[0]          = s1_pix_reg;
        new_col[KSIZE-1]  = s1_pix_reg;
        for (int k = 1; k < KSIZE - 1; k++)
        begin
            lb_wr[k] = lb_rd[k-1];
        end
        for (int k = 0; k < KSIZE - 1; k++)
        begin
            new_col[k] = lb_rd[KSIZE-2-k];
        end
    end

    rwc_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (shift),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    assign cx = DIM_W'(cell_x[HALF]);
    assign ry = DIM_W'(cell_y[HALF]);

    always_comb
    begin
        for (int k = 0; k < KSIZE; k++)
        begin
            if (k < HALF)
            begin
                col_ok[k] = cx >= DIM_W'(HALF - k);
            end
            else
            begin
                col_ok[k] = cx + DIM_W'(k - HALF) < w_eff;
            end
            row_ok[k] = ry >= DIM_W'(KSIZE - 1 - k);
        end
    end

    for (genvar g = 0; g < KSIZE; g++)
    begin : g_cell
        if (g == KSIZE - 1)
        begin : g_head
            rwc_cell #(
                .CW    (CW),
                .RW    (RW),
                .HEAVY (g == HEAVY_COL)
            ) u_cell (
                .clk      (clk),
                .shift    (shift),
                .col_in   (new_col),
                .xtag_in  (s1_col_reg),
                .ytag_in  (s1_row_reg),
                .mask     (row_ok & {KSIZE{col_ok[g]}}),
                .col_out  (cell_col[g]),
                .xtag_out (cell_x[g]),
                .ytag_out (cell_y[g]),
                .csum     (cell_sum[g])
            );
        end
        else
        begin : g_body
            rwc_cell #(
                .CW    (CW),
                .RW    (RW),
                .HEAVY (g == HEAVY_COL)
            ) u_cell (
                .clk      (clk),
                .shift    (shift),
                .col_in   (cell_col[g+1]),
                .xtag_in  (cell_x[g+1]),
                .ytag_in  (cell_y[g+1]),
                .mask     (row_ok & {KSIZE{col_ok[g]}}),
                .col_out  (cell_col[g]),
                .xtag_out (cell_x[g]),
                .ytag_out (cell_y[g]),
                .csum     (cell_sum[g])
            );
        end
    end

    rwc_sum u_sum (
        .clk     (clk),
        .en      (en),
        .col_sum (cell_sum),
        .red     (red_q),
        .green   (green_q),
        .blue    (blue_q)
    );

    assign result_valid = result_valid_reg;
    assign red_out      = red_out_reg;
    assign green_out    = green_out_reg;
    assign blue_out     = blue_out_reg;
    assign frame_end    = frame_end_reg;

endmodule

[hdl/rwc_checker.sv]
// Port-level checks for the RGB 5x5 window convolution core, with the bind
// that attaches them to the top level. Depends on rwc_pkg.
module rwc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_write,
    input logic [rwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [rwc_pkg::CFG_W-1:0]      cfg_data,
    input logic                           pixel_valid,
    input logic                           pixel_ready,
    input logic                           command,
    input logic [rwc_pkg::CH_W-1:0]       red_in,
    input logic [rwc_pkg::CH_W-1:0]       green_in,
    input logic [rwc_pkg::CH_W-1:0]       blue_in,
    input logic                           result_valid,
    input logic                           result_ready,
    input logic [rwc_pkg::CH_W-1:0]       red_out,
    input logic [rwc_pkg::CH_W-1:0]       green_out,
    input logic [rwc_pkg::CH_W-1:0]       blue_out,
    input logic                           frame_end
);
    import rwc_pkg::*;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> pixel_ready)
        else $error("request refused while result register empty");

    a_result_needs_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pixel_ready))
        else $error("result appeared while pipeline held");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out) && $stable(frame_end))
        else $error("stalled result changed");

endmodule

bind rgb_window_convolution_5x5_core rwc_checker u_rwc_checker (.*);

[sim/rgb_window_convolution_5x5_core_tb.sv]
// Testbench for rgb_window_convolution_5x5_core: a directed table, then random frames.
// Results are checked against a local 5x5 filter predictor; depends on rwc_pkg and the core.
`timescale 1ns / 1ps

module rgb_window_convolution_5x5_core_tb;
    import rwc_pkg::*;

    localparam int RING = 4 * MAX_WIDTH_DEF + 8;
    localparam int LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            fend;
    } filt_pix_t;

    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            known;
        filt_pix_t       want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;
    logic pixel_valid = 1'b0;
    logic pixel_ready;
    logic command = CMD_PIXEL;
    logic [CH_W-1:0] red_in = '0;
    logic [CH_W-1:0] green_in = '0;
    logic [CH_W-1:0] blue_in = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic frame_end;

    rgb_window_convolution_5x5_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .command(command),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .result_valid(result_valid), .result_ready(result_ready),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .frame_end(frame_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    pixel_t          line_ring [RING];
    int unsigned     in_col, in_row;
    logic [CFG_W-1:0] width_reg = WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
    filt_pix_t       pending_pixels [$];
    int              errors = 0;
    int              checked = 0;
    int              frames_seen = 0;
    int              cycles = 0;
    bit              calm = 0;
    int              stall_left = 0;

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
        int unsigned d;
        d = v;
        if (d < 1) d = 1;
        if (d > hi) d = hi;
        return d;
    endfunction

    // predict the filtered pixel that this request releases, if any
    function automatic bit filter_pixel(logic cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                        logic [CH_W-1:0] b, output filt_pix_t res);
        int unsigned w, h, frame, lag, p, q, sr, sg, sb, wt;
        int y, x, ny, nx;
        pixel_t pix, v;
        bit hit;
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        frame = w * h;
        lag = 2 * w + 2;
        p = in_row * w + in_col;
        pix = '0;
        hit = 0;
        res = '0;
        if (cmd == CMD_PIXEL && p < frame) pix = {b, g, r};
        line_ring[p % RING] = pix;
        if (p >= lag && p - lag < frame) begin
            q = p - lag;
            y = q / w;
            x = q % w;
            sr = 0; sg = 0; sb = 0;
            for (int ky = 0; ky < KSIZE; ky++)
                for (int kx = 0; kx < KSIZE; kx++) begin
                    ny = y + ky - HALF;
                    nx = x + kx - HALF;
                    wt = (ky == HEAVY_ROW && kx == HEAVY_COL) ? 4 : 1;
                    v = '0;
                    if (ny >= 0 && ny < int'(h) && nx >= 0 && nx < int'(w))
                        v = line_ring[(ny * w + nx) % RING];
                    sr += wt * v[7:0];
                    sg += wt * v[15:8];
                    sb += wt * v[23:16];
                end
            sr /= KERNEL_DIV; sg /= KERNEL_DIV; sb /= KERNEL_DIV;
            res.red = sr > 255 ? SAT_MAX : sr[7:0];
            res.green = sg > 255 ? SAT_MAX : sg[7:0];
            res.blue = sb > 255 ? SAT_MAX : sb[7:0];
            res.fend = (q == frame - 1);
            hit = 1;
        end
        if (p == frame + lag - 1) begin
            in_col = 0;
            in_row = 0;
        end else begin
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        return hit;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        in_col = 0;
        in_row = 0;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_pixel(logic cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                              logic [CH_W-1:0] b, bit known, filt_pix_t typed);
        filt_pix_t res;
        if (!calm && $urandom_range(0, 7) == 0) begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        command <= cmd;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        do @(posedge clk); while (!pixel_ready);
        if (filter_pixel(cmd, r, g, b, res))
            pending_pixels.push_back(known ? typed : res);
    endtask

    task automatic drain;
        pixel_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [CH_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1, 2: return 8'hFF;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left--;
            result_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            result_ready <= 1'b0;
        end else
            result_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        filt_pix_t want;
        if (rst_n && result_valid && result_ready) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h %h %h fe=%b", $time,
                         red_out, green_out, blue_out, frame_end);
            end else begin
                want = pending_pixels.pop_front();
                checked++;
                if (frame_end) frames_seen++;
                if (red_out !== want.red) begin
                    errors++;
                    $display("%0t: red expected %h actual %h", $time, want.red, red_out);
                end
                if (green_out !== want.green) begin
                    errors++;
                    $display("%0t: green expected %h actual %h", $time, want.green, green_out);
                end
                if (blue_out !== want.blue) begin
                    errors++;
                    $display("%0t: blue expected %h actual %h", $time, want.blue, blue_out);
                end
                if (frame_end !== want.fend) begin
                    errors++;
                    $display("%0t: frame_end expected %b actual %b", $time, want.fend, frame_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t: timeout", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    stim_row_t directed [20] = '{
        '{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
        '{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, '{8'd10, 8'd10, 8'd10, 1'b1}},
        '{CMD_PIXEL, 8'h00, 8'h7F, 8'h80, 1'b0, '0},
        '{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
        '{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
        '{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
        '{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'd0, 8'd5, 8'd5, 1'b1}},
        '{CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
        '{CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
        '{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
        '{CMD_PIXEL, 8'h01, 8'h18, 8'hFA, 1'b0, '0},
        '{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_PIXEL, 8'hAA, 8'h55, 8'hAA, 1'b0, '0},
        '{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, '{8'd0, 8'd0, 8'd10, 1'b1}}
    };

    initial
    begin
        int unsigned w, h, frame, lag, span, stop, phase, rand_items;
        logic cmd;
        logic [CFG_W-1:0] wv, hv;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // one-pixel frames: a width and height of zero act as one
        write_reg(REG_IMAGE_WIDTH, 12'd0);
        write_reg(REG_IMAGE_HEIGHT, 12'd0);
        foreach (directed[i])
            send_pixel(directed[i].cmd, directed[i].red, directed[i].green, directed[i].blue,
                       directed[i].known, directed[i].want);
        drain();

        phase = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS || phase < 8) begin
            case (phase)
                2: begin wv = 12'hFFF; hv = 12'd1; end
                4: begin wv = 12'd1; hv = 12'hFFF; end
                6: begin wv = 12'd2048; hv = 12'd2; end
                default: begin
                    wv = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 12));
                    hv = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 8));
                end
            endcase
            calm = rand_items > RANDOM_ITEMS - 200;
            if ($urandom_range(0, 1)) begin
                write_reg(REG_IMAGE_WIDTH, wv);
                write_reg(REG_IMAGE_HEIGHT, hv);
            end else begin
                write_reg(REG_IMAGE_HEIGHT, hv);
                write_reg(REG_IMAGE_WIDTH, wv);
            end
            w = clamp_dim(wv, MAX_WIDTH_DEF);
            h = clamp_dim(hv, MAX_HEIGHT_DEF);
            frame = w * h;
            lag = 2 * w + 2;
            span = frame + lag;
            repeat ($urandom_range(1, 3)) begin
                // cut a frame short now and then; the next register write restarts it
                stop = ($urandom_range(0, 7) == 0) ? $urandom_range(1, span - 1) : span;
                // huge frames: only the opening stretch of the stream
                if (phase == 2 || phase == 4 || phase == 6) stop = 64;
                for (int unsigned i = 0; i < stop; i++) begin
                    if (i < frame) cmd = ($urandom_range(0, 15) == 0) ? CMD_FLUSH : CMD_PIXEL;
                    else cmd = ($urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_FLUSH;
                    if (phase == 3 && i == stop / 2) begin
                        // hold off until the pipeline is empty
                        pixel_valid <= 1'b0;
                        do @(posedge clk); while (pending_pixels.size() != 0);
                    end
                    send_pixel(cmd, pick_sample(), pick_sample(), pick_sample(), 1'b0, '0);
                    rand_items++;
                end
                if (stop != span) break;
            end
            drain();
            phase++;
        end

        $display("covered %0d frame sizes, %0d filtered pixels checked, %0d frame ends",
                 phase + 1, checked, frames_seen);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
